// File: rtl/hma_pkg.sv
// Package for the histogram and moment engine: widths, opcodes, status codes.
// No dependencies; used by hma_divider, histogram_moment_accumulator_core, hma_checker and the test.
package hma_pkg;
	localparam int DefChannels = 32;
	localparam int DefBins     = 256;
	localparam int ChW   = 5;
	localparam int SelW  = 8;
	localparam int StepW = 24;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_SAMP  = 2'd1;
	localparam logic [1:0] OP_RBIN  = 2'd2;
	localparam logic [1:0] OP_RMOM  = 2'd3;

	localparam logic [2:0] ST_BINNED = 3'd0;
	localparam logic [2:0] ST_HIGH   = 3'd1;
	localparam logic [2:0] ST_LOW    = 3'd2;
	localparam logic [2:0] ST_SKIP   = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	localparam logic [2:0] REG_FIRST_STEP = 3'd0;
	localparam logic [2:0] REG_BINS       = 3'd1;
endpackage

// File: rtl/hma_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on hma_pkg (imported for house consistency of widths).
module hma_divider import hma_pkg::*; #(
	parameter int NumW = 42,
	parameter int DenW = 33
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [NumW-1:0] num,
	input  logic [DenW-1:0] den,
	output logic            done,
	output logic [NumW-1:0] quo
);
	localparam int CntW = $clog2(NumW + 1);
	logic [NumW-1:0] quo_q;
	logic [DenW:0]   rem_q;
	logic [DenW-1:0] den_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic [DenW:0]   trial;

	assign trial = {rem_q[DenW-1:0], quo_q[NumW-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CntW'(NumW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CntW'(1)) busy_q <= 1'b0;
		end
	end

	// one shift-subtract step per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!trial[DenW]) begin
				rem_q <= trial;
				quo_q <= {quo_q[NumW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DenW-1:0], quo_q[NumW-1]};
				quo_q <= {quo_q[NumW-2:0], 1'b0};
			end
		end
	end

	assign done = busy_q && cnt_q == CntW'(1);
	assign quo  = quo_q;
endmodule

// File: rtl/histogram_moment_accumulator_core.sv
// Histogram and moment engine: one shared serial divider plus a small sequencer.
// Depends on hma_pkg and hma_divider.
//
// s_tready is low from acceptance until the sequencer is idle again, so the engine
// takes no new item while the sequencer works on one. A kept sample with a non-empty
// range goes from its input beat to its result beat through the channel-state read
// (S_RD) and decision (S_EXEC), the shared 42-step serial divider for the bin index
// (S_DIV), a read and a write-back of the bin memory (S_RMW, S_WR), and the load of
// the output register (S_OUT). Loads, moment reads, burn-in skips and empty-range
// samples pass only S_RD, S_EXEC and S_OUT; bin reads with an in-range select also
// pass S_RMW and S_WR. After reset a clearing pass zeroes all MAX_CHANNELS*MAX_BINS
// words of the bin memory, during which no item is accepted. One result beat per item
// sits in an output register, so the next item is taken and worked on while the beat
// waits; a further finished result then waits in the sequencer until the register
// frees.
module histogram_moment_accumulator_core import hma_pkg::*; #(
	parameter int MAX_CHANNELS = DefChannels,
	parameter int MAX_BINS     = DefBins
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// tdata: opcode[1:0], channel[6:2], sample_value[38:7], range_upper[70:39],
	// step_number[94:71], bin_select[102:95], row_end[103]
	input  logic [103:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// tdata: status[2:0], bin_count[34:3], value_sum[98:35], square_sum[162:99],
	// rows_kept[194:163], zero fill to 200
	output logic [199:0] m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	localparam int CIdxW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int BIdxW = $clog2(MAX_BINS);
	localparam int AddrW = CIdxW + BIdxW;
	localparam int Depth = MAX_CHANNELS * MAX_BINS;
	localparam int NbW   = BIdxW + 1;
	localparam int NumW  = 33 + NbW;
	localparam int DenW  = 33;

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_EXEC = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_RMW  = 3'd4;
	localparam logic [2:0] S_WR   = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;
	localparam logic [2:0] S_RD   = 3'd7;

	// configuration
	logic [StepW-1:0] first_step_q;
	logic [8:0]       bins_q;
	logic             cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_step_q <= '0;
			bins_q       <= 9'd64;
		end else if (cfg_wr) begin
			if (paddr == {REG_FIRST_STEP[0], 2'b00}) first_step_q <= pwdata[StepW-1:0];
			else if (paddr == {REG_BINS[0], 2'b00}) bins_q <= pwdata[8:0];
		end
	end
	always_comb begin
		prdata = '0;
		if (paddr == {REG_FIRST_STEP[0], 2'b00}) prdata = 32'(first_step_q);
		else if (paddr == {REG_BINS[0], 2'b00}) prdata = 32'(bins_q);
	end

	// effective bin count, clamped to 1..MAX_BINS
	logic [NbW-1:0] nb;
	always_comb begin
		if (bins_q == 9'd0) nb = NbW'(1);
		else if (32'(bins_q) > 32'(MAX_BINS)) nb = NbW'(MAX_BINS);
		else nb = NbW'(bins_q);
	end

	// input fields
	logic [1:0]         in_op;
	logic [ChW-1:0]     in_ch;
	logic signed [31:0] in_val, in_up;
	logic [StepW-1:0]   in_step;
	logic [SelW-1:0]    in_sel;
	logic               in_rend;
	assign in_op   = s_tdata[1:0];
	assign in_ch   = s_tdata[6:2];
	assign in_val  = s_tdata[38:7];
	assign in_up   = s_tdata[70:39];
	assign in_step = s_tdata[94:71];
	assign in_sel  = s_tdata[102:95];
	assign in_rend = s_tdata[103];

	// item registers
	logic [2:0]         st_q;
	logic [1:0]         op_q;
	logic [ChW-1:0]     ch_q;
	logic signed [31:0] val_q, up_q;
	logic [StepW-1:0]   step_q;
	logic [SelW-1:0]    sel_q;
	logic               rend_q;
	logic               ch_ok;
	assign ch_ok = 32'(ch_q) < 32'(MAX_CHANNELS);
	logic [CIdxW-1:0] ci;
	assign ci = CIdxW'(ch_q);

	// per-channel state (small arrays, read at one address)
	logic signed [31:0] lo_mem [MAX_CHANNELS];
	logic signed [31:0] hi_mem [MAX_CHANNELS];
	logic signed [63:0] vs_mem [MAX_CHANNELS];
	logic [63:0]        ss_mem [MAX_CHANNELS];
	logic [MAX_CHANNELS-1:0] ch_vld_q;
	logic [31:0]        rows_q;
	logic signed [31:0] lo_s1, hi_s1;
	logic signed [63:0] vs_s1;
	logic [63:0]        ss_s1;

	// bin memory
	logic [31:0]      bin_mem [Depth];
	logic [31:0]      bin_rd_q;
	logic [AddrW-1:0] baddr;
	logic [AddrW:0]   clr_q;

	// divider operands
	logic signed [32:0] num_s, den_s;
	logic               neg_q;
	logic [NumW-1:0]    dnum_q;
	logic [DenW-1:0]    dden_q;
	logic               div_go_q, div_done;
	logic [NumW-1:0]    quo;

	hma_divider #(.NumW(NumW), .DenW(DenW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go_q), .num(dnum_q), .den(dden_q),
		.done(div_done), .quo(quo)
	);

	// result registers and output beat register
	logic [2:0]   r_status_q;
	logic [31:0]  r_cnt_q, r_rows_q;
	logic [63:0]  r_vs_q, r_ss_q;
	logic [194:0] out_q;
	logic         m_valid_q;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {5'd0, out_q};
	assign s_tready = (st_q == S_IDLE);

	// sums
	logic [31:0]        aval;
	logic [63:0]        sq, ss_new;
	logic signed [63:0] vs_new, vext;
	logic [64:0]        ss_sum;
	assign vext  = 64'(val_q);
	assign aval  = val_q[31] ? 32'(-val_q) : 32'(val_q);
	assign sq    = 64'(aval) * 64'(aval);
	assign ss_sum = {1'b0, ss_s1} + {1'b0, sq};
	assign ss_new = ss_sum[64] ? '1 : ss_sum[63:0];
	always_comb begin
		vs_new = vs_s1 + vext;
		if (!vs_s1[63] && !vext[63] && vs_new[63]) vs_new = {1'b0, {63{1'b1}}};
		else if (vs_s1[63] && vext[63] && !vs_new[63]) vs_new = {1'b1, 63'd0};
	end

	assign num_s = 33'(val_q) - 33'(lo_s1);
	assign den_s = 33'(hi_s1) - 33'(lo_s1);

	// item decode, valid in S_EXEC
	logic       kept, div_need, rbin_ok;
	logic [2:0] exec_status;
	assign kept     = ch_ok && op_q == OP_SAMP && step_q >= first_step_q;
	assign div_need = kept && den_s != '0;
	assign rbin_ok  = ch_ok && op_q == OP_RBIN && 32'(sel_q) < 32'(MAX_BINS);
	always_comb begin
		if (ch_ok && op_q == OP_SAMP && !kept) exec_status = ST_SKIP;
		else if (kept && !div_need) exec_status = num_s[32] ? ST_LOW : ST_HIGH;
		else exec_status = ST_DONE;
	end

	// product magnitude, index from quotient
	logic [32:0]     nmag, dmag;
	assign nmag = num_s[32] ? 33'(-num_s) : 33'(num_s);
	assign dmag = den_s[32] ? 33'(-den_s) : 33'(den_s);
	logic too_high, too_low;
	assign too_low  = neg_q && quo != '0;
	assign too_high = !neg_q && quo >= NumW'(nb);
	logic [BIdxW-1:0] idx;
	assign idx = neg_q ? '0 : quo[BIdxW-1:0];
	assign baddr = (op_q == OP_RBIN) ? {ci, BIdxW'(sel_q)} : {ci, idx};

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_CLR;
			clr_q     <= '0;
			m_valid_q <= 1'b0;
			div_go_q  <= 1'b0;
			ch_vld_q  <= '0;
			rows_q    <= '0;
		end else begin
			// output beat: loaded from S_OUT once the previous beat has gone
			if (st_q == S_OUT && (!m_valid_q || m_tready)) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
			div_go_q <= (st_q == S_EXEC) && div_need;
			unique case (st_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AddrW+1)'(Depth - 1)) st_q <= S_IDLE;
				end
				S_IDLE: if (s_tvalid && s_tready) st_q <= S_RD;
				S_RD: st_q <= S_EXEC;
				S_EXEC: begin
					r_status_q <= exec_status;
					r_cnt_q    <= '0;
					r_vs_q     <= (ch_ok && op_q == OP_RMOM) ? vs_s1 : '0;
					r_ss_q     <= (ch_ok && op_q == OP_RMOM) ? ss_s1 : '0;
					r_rows_q   <= (ch_ok && op_q == OP_RMOM) ? rows_q : '0;
					if (ch_ok && (op_q == OP_LOAD || kept)) ch_vld_q[ci] <= 1'b1;
					if (kept && rend_q && rows_q != '1) rows_q <= rows_q + 1'b1;
					if (div_need) st_q <= S_DIV;
					else if (rbin_ok) st_q <= S_RMW;
					else st_q <= S_OUT;
				end
				S_DIV: if (div_done) st_q <= S_RMW;
				S_RMW: st_q <= S_WR;
				S_WR: begin
					if (op_q == OP_RBIN) r_cnt_q <= bin_rd_q;
					else if (too_high) r_status_q <= ST_HIGH;
					else if (too_low) r_status_q <= ST_LOW;
					else r_status_q <= ST_BINNED;
					st_q <= S_OUT;
				end
				S_OUT: if (!m_valid_q || m_tready) begin
					out_q <= {r_rows_q, r_ss_q, r_vs_q, r_cnt_q, r_status_q};
					st_q  <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// payload captures
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q <= in_op; ch_q <= in_ch; val_q <= in_val; up_q <= in_up;
			step_q <= in_step; sel_q <= in_sel; rend_q <= in_rend;
		end
		lo_s1 <= ch_vld_q[ci] ? lo_mem[ci] : '0;
		hi_s1 <= ch_vld_q[ci] ? hi_mem[ci] : '0;
		vs_s1 <= ch_vld_q[ci] ? vs_mem[ci] : '0;
		ss_s1 <= ch_vld_q[ci] ? ss_mem[ci] : '0;
		if (st_q == S_EXEC && ch_ok) begin
			if (op_q == OP_LOAD) begin
				lo_mem[ci] <= val_q;
				hi_mem[ci] <= up_q;
				vs_mem[ci] <= vs_s1;
				ss_mem[ci] <= ss_s1;
			end else if (kept) begin
				vs_mem[ci] <= vs_new;
				ss_mem[ci] <= ss_new;
				lo_mem[ci] <= lo_s1;
				hi_mem[ci] <= hi_s1;
			end
		end
		neg_q  <= num_s[32] ^ den_s[32];
		dnum_q <= NumW'(nmag) * NumW'(nb);
		dden_q <= dmag;
	end

	// bin memory: clear sweep, read, then write back
	always_ff @(posedge clk) begin
		if (st_q == S_CLR) bin_mem[clr_q[AddrW-1:0]] <= '0;
		else if (st_q == S_WR && op_q == OP_SAMP && !too_high && !too_low
				&& bin_rd_q != '1)
			bin_mem[baddr] <= bin_rd_q + 1'b1;
		if (st_q == S_RMW) bin_rd_q <= bin_mem[baddr];
	end
endmodule

// File: bench/hma_checker.sv
// Result checker for the histogram and moment engine: watches both streams,
// predicts each result beat and compares it field by field. Depends on hma_pkg.
module hma_checker import hma_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [103:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [199:0] m_tdata,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_addr,
	input  logic [31:0]  cfg_wdata,
	output int           fail_count,
	output int           pending,
	output int           results_seen
);
	typedef struct packed {
		logic [31:0] rows;
		logic [63:0] sqsum;
		logic [63:0] vsum;
		logic [31:0] cnt;
		logic [2:0]  status;
	} result_t;

	logic [23:0]        burn_in;
	logic [8:0]         nbins_reg;
	logic signed [31:0] lo_tab [DefChannels];
	logic signed [31:0] hi_tab [DefChannels];
	logic [31:0]        hist [DefChannels*DefBins];
	logic signed [63:0] vsums [DefChannels];
	logic [63:0]        sqsums [DefChannels];
	logic [31:0]        row_total;
	result_t            awaited [$];

	// Predict the result of one accepted command beat
	function automatic result_t compute_result(logic [103:0] d);
		result_t r;
		logic [1:0] op;
		logic [4:0] ch;
		logic signed [63:0] v, up, num, den, nb, idx;
		logic [63:0] mag, sq;
		logic [64:0] wide;
		logic signed [64:0] ssum;
		logic [23:0] stepn;
		logic [7:0] sel;
		op = d[1:0]; ch = d[6:2];
		v = 64'(signed'(d[38:7])); up = 64'(signed'(d[70:39]));
		stepn = d[94:71]; sel = d[102:95];
		r = '0; r.status = ST_DONE;
		case (op)
			OP_LOAD: begin
				lo_tab[ch] = v[31:0]; hi_tab[ch] = up[31:0];
			end
			OP_SAMP: begin
				if (stepn < burn_in) r.status = ST_SKIP;
				else begin
					num = v - 64'(lo_tab[ch]);
					den = 64'(hi_tab[ch]) - 64'(lo_tab[ch]);
					nb = 64'((nbins_reg == 0) ? 1 : (nbins_reg > DefBins) ? DefBins : nbins_reg);
					ssum = 65'(vsums[ch]) + 65'(v);
					if (ssum > 65'sh0_7FFF_FFFF_FFFF_FFFF) vsums[ch] = 64'h7FFF_FFFF_FFFF_FFFF;
					else if (ssum < -65'sh0_8000_0000_0000_0000)
						vsums[ch] = 64'h8000_0000_0000_0000;
					else vsums[ch] = ssum[63:0];
					mag = (v < 0) ? -v : v;
					sq = mag * mag;
					wide = {1'b0, sqsums[ch]} + {1'b0, sq};
					sqsums[ch] = wide[64] ? '1 : wide[63:0];
					if (d[103] && row_total != '1) row_total++;
					if (den == 0) r.status = (num < 0) ? ST_LOW : ST_HIGH;
					else begin
						idx = (num * nb) / den;
						if (idx >= nb) r.status = ST_HIGH;
						else if (idx < 0) r.status = ST_LOW;
						else begin
							if (hist[ch*DefBins + idx] != '1) hist[ch*DefBins + idx]++;
							r.status = ST_BINNED;
						end
					end
				end
			end
			OP_RBIN: r.cnt = hist[ch*DefBins + sel];
			default: begin
				r.vsum = vsums[ch]; r.sqsum = sqsums[ch]; r.rows = row_total;
			end
		endcase
		return r;
	endfunction

	// Track registers, queue predictions and compare result beats
	always @(posedge clk or negedge arst_n) begin
		result_t got, want;
		if (!arst_n) begin
			burn_in <= '0; nbins_reg <= 9'd64; row_total <= '0;
			for (int i = 0; i < DefChannels; i++) begin
				lo_tab[i] = '0; hi_tab[i] = '0; vsums[i] = '0; sqsums[i] = '0;
			end
			for (int i = 0; i < DefChannels*DefBins; i++) hist[i] = '0;
			awaited.delete(); fail_count <= 0; results_seen <= 0; pending <= 0;
		end else begin
			if (cfg_we && cfg_addr == 3'(4*REG_FIRST_STEP)) burn_in <= cfg_wdata[23:0];
			if (cfg_we && cfg_addr == 3'(4*REG_BINS)) nbins_reg <= cfg_wdata[8:0];
			if (s_tvalid && s_tready) awaited = {awaited, compute_result(s_tdata)};
			if (m_tvalid && m_tready) begin
				got = m_tdata[194:0];
				results_seen <= results_seen + 1;
				if (awaited.size() == 0) begin
					$display("%0t: unexpected result beat %h", $time, got);
					fail_count <= fail_count + 1;
				end else begin
					want = awaited.pop_front();
					if (got.status !== want.status || got.cnt !== want.cnt
							|| got.vsum !== want.vsum || got.sqsum !== want.sqsum
							|| got.rows !== want.rows || m_tdata[199:195] !== '0) begin
						$display("%0t: mismatch expected st=%0d cnt=%h sum=%h sq=%h rows=%h",
							$time, want.status, want.cnt, want.vsum, want.sqsum, want.rows);
						$display("%0t:          actual st=%0d cnt=%h sum=%h sq=%h rows=%h",
							$time, got.status, got.cnt, got.vsum, got.sqsum, got.rows);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= awaited.size();
		end
	end
endmodule

// File: bench/histogram_moment_accumulator_core_test.sv
// Stimulus and verdict for histogram_moment_accumulator_core: directed and random
// commands, register phases and output stalls. Depends on hma_pkg, hma_checker and the core.
module histogram_moment_accumulator_core_test;
	import hma_pkg::*;

	logic         clk, arst_n;
	logic         s_tvalid, s_tready, m_tvalid, m_tready;
	logic [103:0] s_tdata;
	logic [199:0] m_tdata;
	logic         psel, penable, pwrite, pready;
	logic [2:0]   paddr;
	logic [31:0]  pwdata, prdata;
	int           fail_count, pending, results_seen;
	int           sent;
	bit           hold_off, calm;

	histogram_moment_accumulator_core dut (.*);

	hma_checker chk (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
		.cfg_we(psel && penable && pwrite && pready), .cfg_addr(paddr),
		.cfg_wdata(pwdata), .fail_count, .pending, .results_seen
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#100_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// Output side: random stalls, one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tready <= 1'b0;
		else if (hold_off) m_tready <= 1'b0;
		else m_tready <= calm || ($urandom_range(99) >= 17);
	end

	function automatic logic [103:0] pack_cmd(logic [1:0] op, logic [4:0] ch,
			logic [31:0] v, logic [31:0] up, logic [23:0] stepn, logic [7:0] sel, logic re);
		return {re, sel, stepn, up, v, ch, op};
	endfunction

	// tvalid stays high after a beat; the next beat or drain lowers it
	task automatic send_beat(logic [103:0] d);
		while (!calm && $urandom_range(99) < 17) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] value);
		psel <= 1; pwrite <= 1; paddr <= 3'(4*idx); pwdata <= value; penable <= 0;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		@(posedge clk);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	// Random sample biased into the channel's range
	function automatic logic [31:0] rand_value;
		case ($urandom_range(5))
			0: return $urandom;
			1: return 32'h8000_0000 + $urandom_range(3);
			2: return 32'h7FFF_FFFF - $urandom_range(3);
			default: return 32'(signed'($urandom_range(40000)) - 8000);
		endcase
	endfunction

	task automatic random_phase(int n);
		logic [1:0] op;
		for (int i = 0; i < n; i++) begin
			op = ($urandom_range(9) < 6) ? OP_SAMP : 2'($urandom);
			if (op == OP_LOAD && $urandom_range(1))
				send_beat(pack_cmd(op, 5'($urandom), 32'(-$urandom_range(20000)),
					32'($urandom_range(30000)), 24'd0, 8'd0, 1'b0));
			else
				send_beat(pack_cmd(op, 5'($urandom), (op == OP_LOAD) ? $urandom : rand_value(),
					$urandom, 24'($urandom), 8'($urandom), 1'($urandom)));
		end
	endtask

	initial begin
		arst_n = 0; s_tvalid = 0; s_tdata = '0; m_tready = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		hold_off = 0; calm = 0; sent = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;

		// Directed: loads, extremes, empty and reversed ranges, reads
		send_beat(pack_cmd(OP_LOAD, 5'd0, 32'h0, 32'h0010_0000, 24'd0, 8'd0, 1'b0));
		send_beat(pack_cmd(OP_LOAD, 5'd1, 32'h5, 32'h5, 24'd0, 8'd0, 1'b0));
		send_beat(pack_cmd(OP_LOAD, 5'd2, 32'h0010_0000, 32'h0, 24'd0, 8'd0, 1'b0));
		send_beat(pack_cmd(OP_LOAD, 5'd31, 32'h8000_0000, 32'h7FFF_FFFF, 24'd0, 8'd0, 1'b0));
		send_beat(pack_cmd(OP_SAMP, 5'd0, 32'h0, 32'h0, 24'd0, 8'd0, 1'b1));
		send_beat(pack_cmd(OP_SAMP, 5'd0, 32'h000F_FFFF, 32'h0, 24'hFFFFFF, 8'd0, 1'b1));
		send_beat(pack_cmd(OP_SAMP, 5'd0, 32'h0010_0000, 32'h0, 24'd5, 8'd0, 1'b0));
		send_beat(pack_cmd(OP_SAMP, 5'd0, 32'hFFFF_FFFF, 32'h0, 24'd5, 8'd0, 1'b1));
		send_beat(pack_cmd(OP_SAMP, 5'd0, 32'hFFF0_0000, 32'h0, 24'd5, 8'd0, 1'b0));
		send_beat(pack_cmd(OP_SAMP, 5'd1, 32'h4, 32'h0, 24'd0, 8'd0, 1'b0));
		send_beat(pack_cmd(OP_SAMP, 5'd1, 32'h5, 32'h0, 24'd0, 8'd0, 1'b0));
		send_beat(pack_cmd(OP_SAMP, 5'd2, 32'h0008_0000, 32'h0, 24'd0, 8'd0, 1'b1));
		send_beat(pack_cmd(OP_SAMP, 5'd2, 32'h0000_0001, 32'h0, 24'd0, 8'd0, 1'b1));
		for (int i = 0; i < 4; i++) begin
			send_beat(pack_cmd(OP_SAMP, 5'd3, 32'h8000_0000, 32'h0, 24'd0, 8'd0, 1'b1));
			send_beat(pack_cmd(OP_SAMP, 5'd4, 32'h7FFF_FFFF, 32'h0, 24'd0, 8'd0, 1'b1));
		end
		send_beat(pack_cmd(OP_SAMP, 5'd31, 32'h8000_0000, 32'h0, 24'd0, 8'd0, 1'b1));
		send_beat(pack_cmd(OP_RBIN, 5'd0, 32'h0, 32'h0, 24'd0, 8'd0, 1'b0));
		send_beat(pack_cmd(OP_RBIN, 5'd31, 32'h0, 32'h0, 24'd0, 8'd255, 1'b0));
		send_beat(pack_cmd(OP_RMOM, 5'd3, 32'h0, 32'h0, 24'd0, 8'd0, 1'b0));
		send_beat(pack_cmd(OP_RMOM, 5'd4, 32'h0, 32'h0, 24'd0, 8'd0, 1'b0));
		drain();

		// Register phases, extremes of both
		write_reg(REG_FIRST_STEP, 32'hFF_FFFF); write_reg(REG_BINS, 32'd1);
		random_phase(60); drain();
		write_reg(REG_FIRST_STEP, 32'h80_0000); write_reg(REG_BINS, 32'd256);
		random_phase(150); drain();
		write_reg(REG_FIRST_STEP, 32'd0); write_reg(REG_BINS, 32'd0);
		random_phase(100); drain();
		write_reg(REG_BINS, 32'd511); random_phase(100); drain();

		// Long output hold-off while commands keep coming
		fork
			begin
				hold_off = 1;
				repeat (600) @(posedge clk);
				hold_off = 0;
			end
			random_phase(40);
		join
		drain();

		// Stretch with no idling
		calm = 1; write_reg(REG_BINS, 32'd17); random_phase(200); calm = 0;
		drain();
		write_reg(REG_FIRST_STEP, 32'h00_0400); write_reg(REG_BINS, 32'd64);
		random_phase(560);
		drain();

		$display("Covered %0d command beats and %0d result beats over seven register settings.",
			sent, results_seen);
		if (fail_count == 0 && pending == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end
endmodule
